/* hdl/mrds_pkg.sv */
// ----------------------------------------------------------------------------
// mrds_pkg
// Shared widths, register indexes and the queue item type of the masked
// region depth statistics block.
// ----------------------------------------------------------------------------
package mrds_pkg;

    localparam int XW    = 11;  // pixel column
    localparam int YW    = 10;  // pixel row
    localparam int COLW  = 8;   // one colour component
    localparam int DEPW  = 16;  // depth sample and depth results
    localparam int CNTW  = 22;  // match count
    localparam int SUMW  = 37;  // depth sum
    localparam int BXW   = 12;  // box column bounds
    localparam int BYW   = 11;  // box row bounds

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 12;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_X_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_STOP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STOP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RED     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE    = 3'd6;

    // One classified pixel on its way from the front part to the back part
    typedef struct packed {
        logic            hit;
        logic [DEPW-1:0] depth;
        logic            last;
    } t_item;

endpackage

/* hdl/masked_region_depth_stats.sv */
// ----------------------------------------------------------------------------
// masked_region_depth_stats
// Depth statistics (count, mean, minimum, maximum) of the pixels of one label
// colour inside a configured box, one result per frame.
// ----------------------------------------------------------------------------
// Pixels stream in one per cycle. A pixel matches when it lies inside the
// image, inside the box [box_x_start, box_x_stop) x [box_y_start, box_y_stop)
// and its label colour equals the configured colour. The pixel flagged last
// closes the frame: it is counted first, then a result transfer carries the
// match count, the truncated mean depth, the minimum, the maximum and found.
// With no match, found and every other field are zero. Count and sum
// saturate; a mean beyond the depth range reads as the largest depth.
// Rate: one pixel per cycle for ordinary pixels. A last pixel holds the
// back part through the accumulate step, the bit-serial mean divider and
// the load of the result register, so the next frame starts to see input
// stall once the 4-entry pixel queue has filled. The result register lets
// the next frame accumulate while a result waits.
// Configuration writes are always ready and take effect at once; write them
// only while no frame is in flight. Register indexes: 0 box_x_start,
// 1 box_x_stop, 2 box_y_start, 3 box_y_stop, 4 match_red, 5 match_green,
// 6 match_blue; index 7 is ignored.
// ----------------------------------------------------------------------------
module masked_region_depth_stats #(
    parameter int IMAGE_WIDTH  = 2048,
    parameter int IMAGE_HEIGHT = 1024,
    parameter int DEPTH_BITS   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mrds_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mrds_pkg::CFG_DW-1:0]     i_cfg_data,
    // pixel channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [mrds_pkg::XW-1:0]         i_pixel_x,
    input  logic [mrds_pkg::YW-1:0]         i_pixel_y,
    input  logic [mrds_pkg::COLW-1:0]       i_pix_red,
    input  logic [mrds_pkg::COLW-1:0]       i_pix_green,
    input  logic [mrds_pkg::COLW-1:0]       i_pix_blue,
    input  logic [mrds_pkg::DEPW-1:0]       i_depth_sample,
    input  logic                            i_last_pixel,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [mrds_pkg::CNTW-1:0]       o_match_count,
    output logic [mrds_pkg::DEPW-1:0]       o_mean_depth,
    output logic [mrds_pkg::DEPW-1:0]       o_min_depth,
    output logic [mrds_pkg::DEPW-1:0]       o_max_depth,
    output logic                            o_found
);
    import mrds_pkg::*;

    t_item front_item;
    t_item queue_item;
    logic  queue_full;
    logic  queue_nonempty;
    logic  back_pop;

    // Classify each pixel as it arrives
    mrds_front #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .DEPTH_BITS   (DEPTH_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_pix_red      (i_pix_red),
        .i_pix_green    (i_pix_green),
        .i_pix_blue     (i_pix_blue),
        .i_depth_sample (i_depth_sample),
        .i_last_pixel   (i_last_pixel),
        .o_item         (front_item)
    );

    // Hold input only when the queue is full
    assign o_in_stall = queue_full;

    mrds_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_in_valid),
        .i_item     (front_item),
        .o_full     (queue_full),
        .i_pop      (back_pop),
        .o_nonempty (queue_nonempty),
        .o_item     (queue_item)
    );

    // Accumulate, divide on the frame end, present the result
    mrds_back #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (queue_nonempty),
        .i_item        (queue_item),
        .o_pop         (back_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_match_count (o_match_count),
        .o_mean_depth  (o_mean_depth),
        .o_min_depth   (o_min_depth),
        .o_max_depth   (o_max_depth),
        .o_found       (o_found)
    );

endmodule

/* hdl/mrds_front.sv */
// ----------------------------------------------------------------------------
// mrds_front
// Configuration registers and pixel classification: box, image bounds and
// label colour test, depth masking.
// ----------------------------------------------------------------------------
module mrds_front #(
    parameter int IMAGE_WIDTH  = 2048,
    parameter int IMAGE_HEIGHT = 1024,
    parameter int DEPTH_BITS   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mrds_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mrds_pkg::CFG_DW-1:0]     i_cfg_data,
    input  logic [mrds_pkg::XW-1:0]         i_pixel_x,
    input  logic [mrds_pkg::YW-1:0]         i_pixel_y,
    input  logic [mrds_pkg::COLW-1:0]       i_pix_red,
    input  logic [mrds_pkg::COLW-1:0]       i_pix_green,
    input  logic [mrds_pkg::COLW-1:0]       i_pix_blue,
    input  logic [mrds_pkg::DEPW-1:0]       i_depth_sample,
    input  logic                            i_last_pixel,
    output mrds_pkg::t_item                 o_item
);
    import mrds_pkg::*;

    localparam int DW = (DEPTH_BITS < DEPW) ? DEPTH_BITS : DEPW;
    localparam logic [DEPW-1:0] DepthMask = DEPW'((64'd1 << DW) - 64'd1);
    localparam logic [12:0] ImgW = 13'(IMAGE_WIDTH);
    localparam logic [12:0] ImgH = 13'(IMAGE_HEIGHT);

    logic [BXW-1:0]  r_x_start, r_x_stop;
    logic [BYW-1:0]  r_y_start, r_y_stop;
    logic [COLW-1:0] r_red, r_green, r_blue;

    logic [BXW-1:0] x_ext;
    logic [BYW-1:0] y_ext;
    logic           in_img, in_box, col_eq;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_start <= '0;
            r_x_stop  <= 12'd2048;
            r_y_start <= '0;
            r_y_stop  <= 11'd1024;
            r_red     <= '0;
            r_green   <= '0;
            r_blue    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_X_START: r_x_start <= i_cfg_data[BXW-1:0];
                REG_X_STOP:  r_x_stop  <= i_cfg_data[BXW-1:0];
                REG_Y_START: r_y_start <= i_cfg_data[BYW-1:0];
                REG_Y_STOP:  r_y_stop  <= i_cfg_data[BYW-1:0];
                REG_RED:     r_red     <= i_cfg_data[COLW-1:0];
                REG_GREEN:   r_green   <= i_cfg_data[COLW-1:0];
                REG_BLUE:    r_blue    <= i_cfg_data[COLW-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign x_ext  = {1'b0, i_pixel_x};
    assign y_ext  = {1'b0, i_pixel_y};
    assign in_img = ({2'b00, i_pixel_x} < ImgW) && ({3'b000, i_pixel_y} < ImgH);
    assign in_box = (x_ext >= r_x_start) && (x_ext < r_x_stop) &&
                    (y_ext >= r_y_start) && (y_ext < r_y_stop);
    assign col_eq = (i_pix_red == r_red) && (i_pix_green == r_green) &&
                    (i_pix_blue == r_blue);

    always_comb begin
        o_item.hit   = in_img && in_box && col_eq;
        o_item.depth = i_depth_sample & DepthMask;
        o_item.last  = i_last_pixel;
    end

endmodule

/* hdl/mrds_fifo.sv */
// ----------------------------------------------------------------------------
// mrds_fifo
// Short queue of classified pixels between the front and back parts.
// ----------------------------------------------------------------------------
module mrds_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mrds_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nonempty,
    output mrds_pkg::t_item o_item
);
    import mrds_pkg::*;

    t_item                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]     r_count;
    logic                 do_push, do_pop;

    assign o_full     = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;
    assign o_item     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hdl/mrds_back.sv */
// ----------------------------------------------------------------------------
// mrds_back
// Running count, sum, minimum and maximum; on the last pixel a bit-serial
// restoring divide for the mean, then the result register.
// ----------------------------------------------------------------------------
module mrds_back #(
    parameter int DEPTH_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    input  mrds_pkg::t_item             i_item,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mrds_pkg::CNTW-1:0]   o_match_count,
    output logic [mrds_pkg::DEPW-1:0]   o_mean_depth,
    output logic [mrds_pkg::DEPW-1:0]   o_min_depth,
    output logic [mrds_pkg::DEPW-1:0]   o_max_depth,
    output logic                        o_found
);
    import mrds_pkg::*;

    localparam int DW = (DEPTH_BITS < DEPW) ? DEPTH_BITS : DEPW;
    localparam logic [DEPW-1:0] DepthMax = DEPW'((64'd1 << DW) - 64'd1);
    localparam int STW = $clog2(SUMW);

    localparam logic [1:0] ST_ACC = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;

    logic [1:0]      r_state;
    logic [STW-1:0]  r_step;

    logic [CNTW-1:0] r_count, n_count;
    logic [SUMW-1:0] r_sum,   n_sum;
    logic [DEPW-1:0] r_min,   n_min;
    logic [DEPW-1:0] r_max,   n_max;

    logic [SUMW-1:0] r_quo;
    logic [CNTW-1:0] r_rem, r_den;
    logic [DEPW-1:0] r_res_min, r_res_max;

    logic [SUMW:0]   sum_wide;
    logic [CNTW:0]   rem_sh;
    logic            rem_ge;
    logic            out_free;

    assign o_pop    = i_item_valid && (r_state == ST_ACC);
    assign out_free = !o_out_valid || !i_out_stall;

    // Accumulator update for the pixel at the head of the queue
    always_comb begin
        sum_wide = {1'b0, r_sum} + (SUMW+1)'(i_item.depth);
        n_count  = r_count;
        n_sum    = r_sum;
        n_min    = r_min;
        n_max    = r_max;
        if (i_item.hit) begin
            if (r_count != '1) begin
                n_count = r_count + 1'b1;
            end
            n_sum = sum_wide[SUMW] ? '1 : sum_wide[SUMW-1:0];
            if (i_item.depth < r_min) begin
                n_min = i_item.depth;
            end
            if (i_item.depth > r_max) begin
                n_max = i_item.depth;
            end
        end
    end

    // One quotient bit per step
    assign rem_sh = {r_rem, r_quo[SUMW-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ACC && o_pop && i_item.last) begin
            r_quo     <= n_sum;
            r_rem     <= '0;
            r_den     <= n_count;
            r_res_min <= n_min;
            r_res_max <= n_max;
        end else if (r_state == ST_DIV) begin
            r_quo <= {r_quo[SUMW-2:0], rem_ge};
            r_rem <= rem_ge ? CNTW'(rem_sh - {1'b0, r_den}) : rem_sh[CNTW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            if (r_den == '0) begin
                o_match_count <= '0;
                o_mean_depth  <= '0;
                o_min_depth   <= '0;
                o_max_depth   <= '0;
                o_found       <= 1'b0;
            end else begin
                o_match_count <= r_den;
                o_mean_depth  <= (r_quo > SUMW'(DepthMax)) ? DepthMax : r_quo[DEPW-1:0];
                o_min_depth   <= r_res_min;
                o_max_depth   <= r_res_max;
                o_found       <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACC;
            r_step      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_min       <= DepthMax;
            r_max       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            // drop the taken result unless a new one replaces it this cycle
            if (o_out_valid && !i_out_stall && r_state != ST_OUT) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                ST_ACC: begin
                    if (o_pop) begin
                        if (i_item.last) begin
                            r_count <= '0;
                            r_sum   <= '0;
                            r_min   <= DepthMax;
                            r_max   <= '0;
                            r_step  <= '0;
                            r_state <= ST_DIV;
                        end else begin
                            r_count <= n_count;
                            r_sum   <= n_sum;
                            r_min   <= n_min;
                            r_max   <= n_max;
                        end
                    end
                end
                ST_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STW'(SUMW - 1)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        o_out_valid <= 1'b1;
                        r_state     <= ST_ACC;
                    end else begin
                        o_out_valid <= 1'b1;
                    end
                end
                default: r_state <= ST_ACC;
            endcase
        end
    end

endmodule

/* hdl/mrds_checker.sv */
// ----------------------------------------------------------------------------
// mrds_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mrds_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic [mrds_pkg::CNTW-1:0]       o_match_count,
    input  logic [mrds_pkg::DEPW-1:0]       o_mean_depth,
    input  logic [mrds_pkg::DEPW-1:0]       o_min_depth,
    input  logic [mrds_pkg::DEPW-1:0]       o_max_depth,
    input  logic                            o_found
);
    import mrds_pkg::*;

    // A stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its statistics
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_match_count) &&
            $stable(o_mean_depth) && $stable(o_min_depth) && $stable(o_max_depth))
        else $error("result payload changed while stalled");

    // An empty region reports all zeros
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_match_count == '0 && o_mean_depth == '0 &&
            o_min_depth == '0 && o_max_depth == '0)
        else $error("nonzero statistics without a match");

    // A found region has a count and an ordered range
    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_match_count != '0 && o_min_depth <= o_max_depth)
        else $error("inconsistent statistics for a found region");

endmodule

bind masked_region_depth_stats mrds_checker u_mrds_checker (.*);
